// ----- src/ebtp_pkg.sv -----
// ----------------------------------------------------------------------------
// ebtp_pkg
// Shared types and constants of the entity block text parser.
// ----------------------------------------------------------------------------
package ebtp_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   typedef enum logic [3:0] {
      PH_OUT, PH_OUT_SL, PH_OUT_CM,
      PH_IN, PH_IN_SL, PH_IN_CM,
      PH_KEY, PH_KEY_BS,
      PH_AK, PH_AK_SL, PH_AK_CM,
      PH_VAL, PH_VAL_BS,
      PH_ERR
   } phase_type;

   typedef enum logic [2:0] {
      EV_KEY_BYTE, EV_KEY_DONE, EV_VAL_BYTE,
      EV_PAIR_DONE, EV_BLOCK_DONE, EV_ERROR
   } event_type;

   typedef struct packed {
      event_type   event_res;
      logic [7:0]  out_char;
      logic [6:0]  pairs_in_block;
      logic        last;
   } result_type;

   // results of one input byte; res1 only when two is set
   typedef struct packed {
      logic        two;
      result_type  res0;
      result_type  res1;
   } qentry_type;

   typedef struct packed {
      logic        full;
      logic        head_valid;
   } qstat_type;

endpackage

// ----- src/ebtp_req_if.sv -----
// ----------------------------------------------------------------------------
// ebtp_req_if
// Byte channel into the parser.
// ----------------------------------------------------------------------------
interface ebtp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_text;

   modport source (output valid, output in_byte, output end_of_text, input ready);
   modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

// ----- src/ebtp_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ebtp_rsp_if
// Event channel out of the parser.
// ----------------------------------------------------------------------------
interface ebtp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_res;
   logic [7:0] out_char;
   logic [6:0] pairs_in_block;
   logic       last;

   modport source (output valid, output event_res, output out_char,
                   output pairs_in_block, output last, input ready);
   modport sink   (input valid, input event_res, input out_char,
                   input pairs_in_block, input last, output ready);
endinterface

// ----- src/ebtp_front.sv -----
// ----------------------------------------------------------------------------
// ebtp_front
// Byte classifier and parse state machine; one transfer a cycle unless the
// queue is full; emits zero to two events per byte as one queue entry.
// ----------------------------------------------------------------------------
module ebtp_front
   import ebtp_pkg::*;
#(
   parameter int MAX_PAIRS = 64,
   parameter int KEY_LEN   = 64,
   parameter int VALUE_LEN = 256
) (
   input  logic          clock,
   input  logic          reset,
   ebtp_req_if.sink      req_ch,
   input  qstat_type     qstat,
   output logic          push,
   output qentry_type    wr_entry
);

   localparam int PAIR_W = $clog2(MAX_PAIRS + 1);
   localparam logic [8:0] KEY_LIM = 9'(KEY_LEN - 1);
   localparam logic [8:0] VAL_LIM = 9'(VALUE_LEN - 1);
   localparam logic [PAIR_W-1:0] PAIR_MAX = PAIR_W'(MAX_PAIRS);

   phase_type         phase_ff, phase_in, cur;
   logic [PAIR_W-1:0] pairs_ff, pairs_in;
   logic [7:0]        chars_ff, chars_in;
   logic              drop_ff, drop_in;

   logic              accept, eot, is_sp, again;
   logic [7:0]        b;
   logic              pre_v, main_v;
   event_type         pre_ev, main_ev;
   logic [7:0]        main_ch;
   logic [PAIR_W+6:0] pre_pext, main_pext;
   result_type        pre_res, main_res;

   assign req_ch.ready = !qstat.full;
   assign accept = req_ch.valid && req_ch.ready;
   assign b      = req_ch.in_byte;
   assign eot    = req_ch.end_of_text || (b == CH_NUL);
   assign is_sp  = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);

   always_comb begin
      phase_in = phase_ff;
      pairs_in = pairs_ff;
      chars_in = chars_ff;
      drop_in  = drop_ff;
      pre_v    = 1'b0;
      pre_ev   = EV_KEY_BYTE;
      main_v   = 1'b0;
      main_ev  = EV_KEY_BYTE;
      main_ch  = 8'h00;
      cur      = phase_ff;
      again    = 1'b0;
      if (eot) begin
         case (phase_ff) inside
            PH_IN, PH_IN_SL, PH_IN_CM, PH_KEY, PH_KEY_BS,
            PH_AK, PH_AK_SL, PH_AK_CM, PH_VAL, PH_VAL_BS: begin
               main_v  = 1'b1;
               main_ev = EV_ERROR;
            end
            default: ;
         endcase
         phase_in = PH_OUT;
         drop_in  = 1'b0;
         chars_in = 8'h00;
      end else begin
         // escape and slash lookahead; may hand the byte to the base phase
         unique case (phase_ff)
            PH_OUT_SL: begin
               if (b == CH_SLASH) begin
                  phase_in = PH_OUT_CM;
               end else begin
                  cur   = PH_OUT;
                  again = 1'b1;
               end
            end
            PH_IN_SL: begin
               if (b == CH_SLASH) begin
                  phase_in = PH_IN_CM;
               end else begin
                  phase_in = PH_IN;
                  cur      = PH_IN;
                  again    = 1'b1;
               end
            end
            PH_KEY_BS: begin
               phase_in = PH_KEY;
               if (b != CH_NL) begin
                  if (!drop_ff && ({1'b0, chars_ff} < KEY_LIM)) begin
                     chars_in = chars_ff + 8'd1;
                     pre_v    = 1'b1;
                     pre_ev   = EV_KEY_BYTE;
                  end
                  cur   = PH_KEY;
                  again = 1'b1;
               end
            end
            PH_VAL_BS: begin
               phase_in = PH_VAL;
               if (b != CH_NL) begin
                  if (!drop_ff && ({1'b0, chars_ff} < VAL_LIM)) begin
                     chars_in = chars_ff + 8'd1;
                     pre_v    = 1'b1;
                     pre_ev   = EV_VAL_BYTE;
                  end
                  cur   = PH_VAL;
                  again = 1'b1;
               end
            end
            default: again = 1'b1;
         endcase

         if (again) begin
            unique case (cur)
               PH_OUT_CM: if (b == CH_NL) phase_in = PH_OUT;
               PH_IN_CM:  if (b == CH_NL) phase_in = PH_IN;
               PH_AK_CM:  if (b == CH_NL) phase_in = PH_AK;
               PH_ERR: ;
               PH_IN: begin
                  if (!is_sp) begin
                     if (b == CH_SLASH) begin
                        phase_in = PH_IN_SL;
                     end else if (b == CH_RBRACE) begin
                        main_v   = 1'b1;
                        main_ev  = EV_BLOCK_DONE;
                        phase_in = PH_OUT;
                     end else if (b == CH_QUOTE) begin
                        drop_in  = (pairs_ff >= PAIR_MAX);
                        chars_in = 8'h00;
                        phase_in = PH_KEY;
                     end
                  end
               end
               PH_KEY: begin
                  if (b == CH_QUOTE) begin
                     main_v   = !drop_ff;
                     main_ev  = EV_KEY_DONE;
                     phase_in = PH_AK;
                  end else if (b == CH_BSLASH) begin
                     phase_in = PH_KEY_BS;
                  end else if (!drop_ff && ({1'b0, chars_in} < KEY_LIM)) begin
                     chars_in = chars_in + 8'd1;
                     main_v   = 1'b1;
                     main_ev  = EV_KEY_BYTE;
                     main_ch  = b;
                  end
               end
               PH_AK: begin
                  if (!is_sp) begin
                     if (b == CH_SLASH) begin
                        phase_in = PH_AK_SL;
                     end else if (b == CH_QUOTE) begin
                        chars_in = 8'h00;
                        phase_in = PH_VAL;
                     end else begin
                        main_v   = 1'b1;
                        main_ev  = EV_ERROR;
                        phase_in = PH_ERR;
                     end
                  end
               end
               PH_AK_SL: begin
                  if (b == CH_SLASH) begin
                     phase_in = PH_AK_CM;
                  end else begin
                     main_v   = 1'b1;
                     main_ev  = EV_ERROR;
                     phase_in = PH_ERR;
                  end
               end
               PH_VAL: begin
                  if (b == CH_QUOTE) begin
                     if (!drop_ff) begin
                        pairs_in = pairs_ff + PAIR_W'(1);
                        main_v   = 1'b1;
                        main_ev  = EV_PAIR_DONE;
                     end
                     phase_in = PH_IN;
                  end else if (b == CH_BSLASH) begin
                     phase_in = PH_VAL_BS;
                  end else if (!drop_ff && ({1'b0, chars_in} < VAL_LIM)) begin
                     chars_in = chars_in + 8'd1;
                     main_v   = 1'b1;
                     main_ev  = EV_VAL_BYTE;
                     main_ch  = b;
                  end
               end
               default: begin
                  phase_in = PH_OUT;
                  if (!is_sp) begin
                     if (b == CH_SLASH) begin
                        phase_in = PH_OUT_SL;
                     end else if (b == CH_LBRACE) begin
                        pairs_in = '0;
                        drop_in  = 1'b0;
                        chars_in = 8'h00;
                        phase_in = PH_IN;
                     end
                  end
               end
            endcase
         end
      end
   end

   assign pre_pext  = {7'b0, pairs_ff};
   assign main_pext = {7'b0, pairs_in};

   always_comb begin
      pre_res.event_res      = pre_ev;
      pre_res.out_char       = CH_BSLASH;
      pre_res.pairs_in_block = pre_pext[6:0];
      pre_res.last           = !main_v;
      main_res.event_res      = main_ev;
      main_res.out_char       = main_ch;
      main_res.pairs_in_block = main_pext[6:0];
      main_res.last           = 1'b1;
      if (pre_v) begin
         wr_entry.two  = main_v;
         wr_entry.res0 = pre_res;
         wr_entry.res1 = main_res;
      end else begin
         wr_entry.two  = 1'b0;
         wr_entry.res0 = main_res;
         wr_entry.res1 = main_res;
      end
   end

   assign push = accept && (pre_v || main_v);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OUT;
         pairs_ff <= '0;
         chars_ff <= 8'h00;
         drop_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pairs_ff <= pairs_in;
         chars_ff <= chars_in;
         drop_ff  <= drop_in;
      end
   end

   a_two_last: assert property (@(posedge clock) disable iff (reset)
      push && wr_entry.two |-> !wr_entry.res0.last && wr_entry.res1.last)
      else $error("two-result entry has wrong last flags");

   a_one_last: assert property (@(posedge clock) disable iff (reset)
      push && !wr_entry.two |-> wr_entry.res0.last)
      else $error("single-result entry not marked last");

   a_pairs_cap: assert property (@(posedge clock) disable iff (reset)
      pairs_ff <= PAIR_MAX)
      else $error("stored pair count above limit");

endmodule

// ----- src/ebtp_queue.sv -----
// ----------------------------------------------------------------------------
// ebtp_queue
// Short FIFO of per-byte event entries between parser and output stage.
// ----------------------------------------------------------------------------
module ebtp_queue
   import ebtp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  qentry_type  wr_entry,
   input  logic        pop,
   output qentry_type  head,
   output qstat_type   qstat
);

   qentry_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff, count_in;

   assign qstat.full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign qstat.head_valid = (count_ff != '0);
   assign head             = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + (QPTR_W+1)'(1);
         2'b01:   count_in = count_ff - (QPTR_W+1)'(1);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && qstat.full))
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> qstat.head_valid)
      else $error("queue underflow");

endmodule

// ----- src/ebtp_back.sv -----
// ----------------------------------------------------------------------------
// ebtp_back
// Output stage: unpacks queue entries into single event transfers through
// an output register.
// ----------------------------------------------------------------------------
module ebtp_back
   import ebtp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  qentry_type  head,
   input  qstat_type   qstat,
   output logic        pop,
   ebtp_rsp_if.source  rsp_ch
);

   logic        out_valid_ff;
   result_type  out_ff;
   logic        sub_ff, sub_in;
   logic        load;

   assign load   = qstat.head_valid && (!out_valid_ff || rsp_ch.ready);
   assign pop    = load && (sub_ff || !head.two);
   assign sub_in = load ? !pop : sub_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= sub_ff ? head.res1 : head.res0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         sub_ff       <= 1'b0;
      end else begin
         sub_ff <= sub_in;
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.event_res      = out_ff.event_res;
   assign rsp_ch.out_char       = out_ff.out_char;
   assign rsp_ch.pairs_in_block = out_ff.pairs_in_block;
   assign rsp_ch.last           = out_ff.last;

   a_sub_two: assert property (@(posedge clock) disable iff (reset)
      sub_ff |-> qstat.head_valid && head.two)
      else $error("second-result select without a two-result entry");

endmodule

// ----- src/entity_block_text_parser_core.sv -----
// ----------------------------------------------------------------------------
// entity_block_text_parser_core
// Streaming parser for brace-delimited blocks of quoted key/value pairs.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle while the queue has room, also bytes giving
// no event, and emits key/value bytes and key-done, pair-done, block-done and
// error events, one per rsp transfer, with last set on each byte's final event.
// The parse state machine classifies each byte in the cycle it is taken and
// writes its events to a four-entry queue; an output register drains that
// queue at one event per cycle unless rsp stalls, so a byte with two events
// (an escape followed by a stored byte, a key close or a pair close) takes
// two rsp transfers. Events pass the queue and the output register. req
// stalls only when the queue is full. No initialization pass after reset.
// ----------------------------------------------------------------------------
module entity_block_text_parser_core
   import ebtp_pkg::*;
#(
   parameter int MAX_PAIRS = 64,
   parameter int KEY_LEN   = 64,
   parameter int VALUE_LEN = 256
) (
   input  logic        clock,
   input  logic        reset,
   ebtp_req_if.sink    req_ch,
   ebtp_rsp_if.source  rsp_ch
);

   logic        push, pop;
   qentry_type  wr_entry, head;
   qstat_type   qstat;

   ebtp_front #(
      .MAX_PAIRS (MAX_PAIRS),
      .KEY_LEN   (KEY_LEN),
      .VALUE_LEN (VALUE_LEN)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .qstat    (qstat),
      .push     (push),
      .wr_entry (wr_entry)
   );

   ebtp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_entry (wr_entry),
      .pop      (pop),
      .head     (head),
      .qstat    (qstat)
   );

   ebtp_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .qstat  (qstat),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for entity_block_text_parser_core.
// ----------------------------------------------------------------------------
// A queue of text bytes is built up front: a short directed lump, then random
// blocks of quoted pairs, mostly well formed, some cut off by end of text or
// broken after a key, plus raw noise. One block hits the pair limit and both
// length limits. Every accepted byte is run through a local parser model and
// the events it should give are queued. Each event transfer is checked field
// by field against the oldest queued event. Both channels stall at random,
// the event side is held off once to make the byte side back up, and the byte
// side pauses at least once until all events are out.
// ----------------------------------------------------------------------------
module tb_top
   import ebtp_pkg::*;
();

   localparam int PAIR_LIMIT  = 64;
   localparam int KEY_LIMIT   = 64;
   localparam int VALUE_LIMIT = 256;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TEXT_TARGET = 850;
   localparam int HOLD_CYCLES = 120;

   typedef struct {
      logic [7:0] ch;
      logic       eot;
      bit         pause;
   } text_item_type;

   typedef enum int {
      CUT_BEFORE_KEY, CUT_IN_KEY, CUT_AFTER_KEY, CUT_IN_VALUE,
      BAD_AFTER_KEY, WHOLE_PAIR
   } pair_end_type;

   logic clock;
   logic reset;

   ebtp_req_if req_bus ();
   ebtp_rsp_if rsp_bus ();

   entity_block_text_parser_core #(
      .MAX_PAIRS (PAIR_LIMIT),
      .KEY_LEN   (KEY_LIMIT),
      .VALUE_LEN (VALUE_LIMIT)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   text_item_type text_queue[$];
   result_type pending_events[$];
   result_type step_events[$];

   // parser model state
   phase_type  parse_ph;
   logic [6:0] pair_count;
   int         char_count;
   bit         pair_skip;

   int error_count;
   int sent_count;
   int event_count;
   int cycle_count;
   int total_items;
   int phase_a_end;
   int phase_b_end;
   int hold_at;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic flag_error(input string msg);
      if (error_count < 30)
         $display("ERROR: event %0d: %s", event_count, msg);
      error_count++;
   endtask

   // ---------------------------------------------------------------- model

   function automatic bit is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic void note_event(event_type ev, logic [7:0] c);
      result_type r;
      if (step_events.size() >= 2)
         return;
      r.event_res      = ev;
      r.out_char       = c;
      r.pairs_in_block = pair_count;
      r.last           = 1'b0;
      step_events.push_back(r);
   endfunction

   function automatic void keep_char(logic [7:0] c, bit is_key);
      int lim;
      lim = is_key ? KEY_LIMIT - 1 : VALUE_LIMIT - 1;
      if (pair_skip)
         return;
      if (char_count < lim) begin
         char_count++;
         if (is_key)
            note_event(EV_KEY_BYTE, c);
         else
            note_event(EV_VAL_BYTE, c);
      end
   endfunction

   task automatic parse_transfer(input logic [7:0] b, input logic eot);
      bit again;
      step_events.delete();
      if (eot || b == CH_NUL) begin
         if (parse_ph >= PH_IN && parse_ph <= PH_VAL_BS)
            note_event(EV_ERROR, CH_NUL);
         parse_ph   = PH_OUT;
         pair_skip  = 1'b0;
         char_count = 0;
      end else begin
         again = 1'b1;
         while (again) begin
            again = 1'b0;
            case (parse_ph)
               PH_OUT_SL: begin
                  if (b == CH_SLASH) begin
                     parse_ph = PH_OUT_CM;
                  end else begin
                     parse_ph = PH_OUT;
                     again    = 1'b1;
                  end
               end
               PH_OUT_CM: begin
                  if (b == CH_NL)
                     parse_ph = PH_OUT;
               end
               PH_IN: begin
                  if (is_blank(b)) begin
                  end else if (b == CH_SLASH) begin
                     parse_ph = PH_IN_SL;
                  end else if (b == CH_RBRACE) begin
                     note_event(EV_BLOCK_DONE, CH_NUL);
                     parse_ph = PH_OUT;
                  end else if (b == CH_QUOTE) begin
                     pair_skip  = pair_count >= PAIR_LIMIT;
                     char_count = 0;
                     parse_ph   = PH_KEY;
                  end
               end
               PH_IN_SL: begin
                  if (b == CH_SLASH) begin
                     parse_ph = PH_IN_CM;
                  end else begin
                     parse_ph = PH_IN;
                     again    = 1'b1;
                  end
               end
               PH_IN_CM: begin
                  if (b == CH_NL)
                     parse_ph = PH_IN;
               end
               PH_KEY: begin
                  if (b == CH_QUOTE) begin
                     if (!pair_skip)
                        note_event(EV_KEY_DONE, CH_NUL);
                     parse_ph = PH_AK;
                  end else if (b == CH_BSLASH) begin
                     parse_ph = PH_KEY_BS;
                  end else begin
                     keep_char(b, 1'b1);
                  end
               end
               PH_KEY_BS: begin
                  parse_ph = PH_KEY;
                  if (b != CH_NL) begin
                     keep_char(CH_BSLASH, 1'b1);
                     again = 1'b1;
                  end
               end
               PH_AK: begin
                  if (is_blank(b)) begin
                  end else if (b == CH_SLASH) begin
                     parse_ph = PH_AK_SL;
                  end else if (b == CH_QUOTE) begin
                     char_count = 0;
                     parse_ph   = PH_VAL;
                  end else begin
                     note_event(EV_ERROR, CH_NUL);
                     parse_ph = PH_ERR;
                  end
               end
               PH_AK_SL: begin
                  if (b == CH_SLASH) begin
                     parse_ph = PH_AK_CM;
                  end else begin
                     note_event(EV_ERROR, CH_NUL);
                     parse_ph = PH_ERR;
                  end
               end
               PH_AK_CM: begin
                  if (b == CH_NL)
                     parse_ph = PH_AK;
               end
               PH_VAL: begin
                  if (b == CH_QUOTE) begin
                     if (!pair_skip) begin
                        pair_count++;
                        note_event(EV_PAIR_DONE, CH_NUL);
                     end
                     parse_ph = PH_IN;
                  end else if (b == CH_BSLASH) begin
                     parse_ph = PH_VAL_BS;
                  end else begin
                     keep_char(b, 1'b0);
                  end
               end
               PH_VAL_BS: begin
                  parse_ph = PH_VAL;
                  if (b != CH_NL) begin
                     keep_char(CH_BSLASH, 1'b0);
                     again = 1'b1;
                  end
               end
               PH_ERR: begin
               end
               default: begin
                  parse_ph = PH_OUT;
                  if (is_blank(b)) begin
                  end else if (b == CH_SLASH) begin
                     parse_ph = PH_OUT_SL;
                  end else if (b == CH_LBRACE) begin
                     pair_count = '0;
                     pair_skip  = 1'b0;
                     char_count = 0;
                     parse_ph   = PH_IN;
                  end
               end
            endcase
         end
      end
      if (step_events.size() > 0)
         step_events[step_events.size() - 1].last = 1'b1;
      foreach (step_events[i])
         pending_events.push_back(step_events[i]);
   endtask

   // ------------------------------------------------------------- stimulus

   task automatic push_item(input logic [7:0] ch, input logic eot, input bit pause);
      text_item_type it;
      it.ch    = ch;
      it.eot   = eot;
      it.pause = pause;
      text_queue.push_back(it);
   endtask

   task automatic add_byte(input logic [7:0] ch);
      push_item(ch, 1'b0, 1'b0);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         add_byte(s[i]);
   endtask

   task automatic add_end();
      if ($urandom_range(0, 1))
         push_item(CH_NUL, 1'b0, 1'b0);
      else
         push_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
   endtask

   function automatic logic [7:0] pick_stray();
      if ($urandom_range(0, 1))
         return 8'(8'h61 + $urandom_range(0, 25));
      return 8'(8'h80 + $urandom_range(0, 127));
   endfunction

   // whitespace and comments; loose also allows lone slashes and stray bytes
   task automatic add_gap(input bit loose);
      logic [7:0] c;
      repeat ($urandom_range(0, 2)) begin
         case ($urandom_range(0, loose ? 4 : 2))
            0: add_byte(CH_SPACE);
            1: add_byte(($urandom_range(0, 5) == 0) ? CH_SPACE
                                                    : 8'(8'h09 + $urandom_range(0, 4)));
            2: begin
               add_text("//");
               repeat ($urandom_range(0, 4)) begin
                  do c = 8'($urandom_range(1, 255)); while (c == CH_NL);
                  add_byte(c);
               end
               add_byte(CH_NL);
            end
            3: begin
               add_byte(CH_SLASH);
               add_byte($urandom_range(0, 1) ? CH_SPACE : pick_stray());
            end
            default: add_byte(pick_stray());
         endcase
      end
   endtask

   task automatic add_content();
      logic [7:0] c;
      repeat ($urandom_range(0, 7)) begin
         case ($urandom_range(0, 19))
            0: add_text("\\\n");
            1: begin
               add_byte(CH_BSLASH);
               do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE);
               add_byte(c);
            end
            2, 3, 4: begin
               do c = 8'($urandom_range(1, 255));
               while (c == CH_QUOTE || c == CH_BSLASH);
               add_byte(c);
            end
            default: add_byte(8'(8'h61 + $urandom_range(0, 25)));
         endcase
      end
   endtask

   task automatic add_pair(input pair_end_type how);
      if (how == CUT_BEFORE_KEY) begin
         if ($urandom_range(0, 1))
            add_text("//x");
         return;
      end
      add_byte(CH_QUOTE);
      add_content();
      if (how == CUT_IN_KEY) begin
         if ($urandom_range(0, 1))
            add_byte(CH_BSLASH);
         return;
      end
      add_byte(CH_QUOTE);
      if (how == CUT_AFTER_KEY)
         return;
      if (how == BAD_AFTER_KEY) begin
         if ($urandom_range(0, 1))
            add_byte(CH_SPACE);
         if ($urandom_range(0, 1))
            add_byte(CH_SLASH);
         add_byte(pick_stray());
         return;
      end
      add_gap(1'b0);
      add_byte(CH_QUOTE);
      add_content();
      if (how == CUT_IN_VALUE) begin
         if ($urandom_range(0, 1))
            add_byte(CH_BSLASH);
         return;
      end
      add_byte(CH_QUOTE);
   endtask

   task automatic add_block();
      int kind;
      int npairs;
      int cut;
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
         repeat ($urandom_range(1, 10))
            add_byte(8'($urandom_range(0, 255)));
         add_end();
         return;
      end
      add_gap(1'b1);
      push_item(CH_LBRACE, 1'b0, $urandom_range(0, 11) == 0);
      npairs = $urandom_range(0, 4);
      cut    = (kind >= 7) ? $urandom_range(0, npairs) : npairs + 1;
      for (int i = 0; i <= npairs; i++) begin
         add_gap(1'b1);
         if (i == cut) begin
            if (kind == 7) begin
               add_pair(pair_end_type'($urandom_range(0, 3)));
            end else begin
               add_pair(BAD_AFTER_KEY);
               repeat ($urandom_range(0, 4))
                  add_byte(8'($urandom_range(1, 255)));
            end
            add_end();
            return;
         end
         if (i < npairs)
            add_pair(WHOLE_PAIR);
      end
      add_byte(CH_RBRACE);
      if ($urandom_range(0, 3) == 0)
         add_end();
   endtask

   // ---------------------------------------------------------------- idling

   function automatic int send_idle_pct();
      if (sent_count < phase_a_end) return 29;
      if (sent_count < phase_b_end) return 79;
      return 0;
   endfunction

   function automatic int recv_idle_pct();
      if (sent_count < phase_a_end) return 79;
      if (sent_count < phase_b_end) return 29;
      return 0;
   endfunction

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      text_item_type nxt;
      bit            offer;
      if (reset) begin
         req_bus.valid       <= 1'b0;
         req_bus.in_byte     <= '0;
         req_bus.end_of_text <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            parse_transfer(req_bus.in_byte, req_bus.end_of_text);
            sent_count++;
         end
         if (!(req_bus.valid && !req_bus.ready)) begin
            offer = 1'b0;
            if (text_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
               if (!text_queue[0].pause || pending_events.size() == 0) begin
                  nxt   = text_queue.pop_front();
                  offer = 1'b1;
                  req_bus.in_byte     <= nxt.ch;
                  req_bus.end_of_text <= nxt.eot;
               end
            end
            req_bus.valid <= offer;
         end
      end
   end

   // ------------------------------------------------------------- receiver

   int hold_left;
   bit hold_done;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (!hold_done && sent_count >= hold_at) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= $urandom_range(0, 99) >= recv_idle_pct();
         end
      end
   end

   // --------------------------------------------------------------- monitor

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_events.size() == 0) begin
            flag_error($sformatf("unexpected transfer, event %0d char %02h",
                                 rsp_bus.event_res, rsp_bus.out_char));
         end else begin
            want = pending_events.pop_front();
            if (rsp_bus.event_res !== want.event_res)
               flag_error($sformatf("event_res %0d, want %0d",
                                    rsp_bus.event_res, want.event_res));
            if (rsp_bus.out_char !== want.out_char)
               flag_error($sformatf("out_char %02h, want %02h",
                                    rsp_bus.out_char, want.out_char));
            if (rsp_bus.pairs_in_block !== want.pairs_in_block)
               flag_error($sformatf("pairs_in_block %0d, want %0d",
                                    rsp_bus.pairs_in_block, want.pairs_in_block));
            if (rsp_bus.last !== want.last)
               flag_error($sformatf("last %0b, want %0b", rsp_bus.last, want.last));
         end
         event_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("entity_block_text_parser_core verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------ main

   initial begin
      bit limits_done;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.in_byte     = '0;
      req_bus.end_of_text = 1'b0;
      rsp_bus.ready       = 1'b0;
      parse_ph            = PH_OUT;
      pair_count          = '0;
      char_count          = 0;
      pair_skip           = 1'b0;
      error_count         = 0;
      sent_count          = 0;
      event_count         = 0;
      cycle_count         = 0;
      hold_left           = 0;
      hold_done           = 1'b0;
      limits_done         = 1'b0;

      // lone slashes, escape before quote, comment after key, high byte,
      // escaped newline, escape closing a value, block done
      add_text("/{/\"\\\"//\n\"");
      add_byte(8'hFF);
      add_text("\\\n\\\"}");
      // missing value quote, then bytes ignored until end of text
      add_text("{\"\"v}");
      push_item(8'h41, 1'b1, 1'b0);
      // end of text on a pending escape inside a key, then outside a block
      add_text("{\"\\");
      add_byte(CH_NUL);
      push_item(8'hFF, 1'b1, 1'b0);

      push_item(CH_SPACE, 1'b0, 1'b1);
      while (text_queue.size() < TEXT_TARGET) begin
         if (!limits_done && text_queue.size() > 150) begin
            // truncated key and value, then pairs up to and past the limit
            add_text("{\"");
            repeat (66) add_byte(8'(8'h61 + $urandom_range(0, 25)));
            add_text("\"\"");
            repeat (258) add_byte(8'(8'h61 + $urandom_range(0, 25)));
            add_byte(CH_QUOTE);
            repeat (64) add_text("\"\"\"\"");
            add_text("\"k\\x\"\"v\"}");
            limits_done = 1'b1;
         end
         add_block();
      end

      total_items = text_queue.size();
      phase_a_end = total_items / 3;
      phase_b_end = 2 * total_items / 3;
      hold_at     = phase_b_end + 30;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (sent_count < total_items) @(posedge clock);
      while (pending_events.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("entity_block_text_parser_core verification clean");
      else
         $display("entity_block_text_parser_core verification failed");
      $finish;
   end

endmodule
